/* src/bba_pkg.sv */
// Shared definitions for the bitmap block allocator: operation and status
// codes, default sizes, and the command/status bundles between controller
// and datapath. No dependencies.
`default_nettype none

package bba_pkg;

  // Default sizing of the managed block space
  localparam int MAX_BLOCKS_DEF = 16384;
  localparam int WORD_BITS_DEF  = 32;
  // Block total loaded at reset (capped at the block space)
  localparam int TOTAL_RESET    = 16384;

  // Operation codes carried by the kind field
  localparam logic [2:0] KIND_ALLOC  = 3'd0;
  localparam logic [2:0] KIND_FREE   = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_WRITE  = 3'd3;
  localparam logic [2:0] KIND_FORMAT = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_RESV  = 1'b1;

  // Bitmap word address selection
  typedef enum logic [1:0] {
    ADDR_HOLD,
    ADDR_ZERO,
    ADDR_BLK,
    ADDR_NEXT
  } addr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      capture;     // latch the input item
    logic      rd_en;       // read bitmap word at the next address
    addr_sel_e addr_sel;    // next word address
    logic      res_early;   // result without bitmap access (error, no-op)
    logic      scan_hit;    // claim the first free bit of the scanned word
    logic      rmw;         // single-bit free, read or write
    logic      sweep;       // write one word of a format or clearing pass
    logic      sweep_zero;  // sweep writes all zero (post-reset clear)
    logic      fmt_done;    // reload the free counter after format
    logic      load_out;    // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] kind;       // captured operation
    logic       early;      // item finishes without touching the bitmap
    logic       hit;        // scanned word holds a free in-range bit
    logic       scan_last;  // scanned word is the last in range
    logic       sweep_last; // sweep is at the last word
    logic       out_free;   // output register can take a result
  } st_t;

endpackage

`default_nettype wire

/* src/bba_dp.sv */
// Datapath of the bitmap block allocator: bitmap memory, free counter,
// configuration registers, scan logic and output register.
// Depends on bba_pkg.
`default_nettype none

module bba_dp #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [$clog2(MAX_BLOCKS):0]   cfg_data_i,
  // input item payload
  input  logic [2:0]                    in_kind_i,
  input  logic [$clog2(MAX_BLOCKS)-1:0] in_block_number_i,
  input  logic                          in_bit_value_i,
  // output channel
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [1:0]                    out_status_o,
  output logic [$clog2(MAX_BLOCKS)-1:0] out_result_block_o,
  output logic                          out_result_bit_o,
  output logic [$clog2(MAX_BLOCKS):0]   out_free_count_o,
  // controller link
  input  bba_pkg::cmd_t                 cmd_i,
  output bba_pkg::st_t                  st_o
);

  localparam int BLK_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = BLK_W + 1;
  localparam int IDX_W  = $clog2(WORD_BITS);
  localparam int AW     = BLK_W - IDX_W;
  localparam int NWORDS = MAX_BLOCKS / WORD_BITS;
  localparam int TOTAL_RST =
    (bba_pkg::TOTAL_RESET < MAX_BLOCKS) ? bba_pkg::TOTAL_RESET : MAX_BLOCKS;
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] TOTAL_CNT = CNT_W'(TOTAL_RST);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(NWORDS - 1);

  // Mask of the bits of a word whose block number lies below lim
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] base,
                                                    input logic [CNT_W-1:0] lim);
    logic [WORD_BITS-1:0] m;
    logic [CNT_W:0]       pos;
    m   = '0;
    pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      pos  = {1'b0, base} + (CNT_W+1)'(b);
      m[b] = (pos < {1'b0, lim});
    end
    return m;
  endfunction

  logic [WORD_BITS-1:0] mem [NWORDS];

  logic [CNT_W-1:0]     total_q, resv_q, cnt_q, cnt_d;
  logic [2:0]           kind_q;
  logic [BLK_W-1:0]     blk_q;
  logic                 bv_q;
  logic [AW-1:0]        addr_q, addr_d;
  logic [WORD_BITS-1:0] rd_data_q;
  logic [1:0]           res_status_q, res_status_d;
  logic [BLK_W-1:0]     res_block_q, res_block_d;
  logic                 res_bit_q, res_bit_d;
  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [BLK_W-1:0]     out_block_q;
  logic                 out_bit_q;
  logic [CNT_W-1:0]     out_cnt_q;

  logic [CNT_W-1:0]     eff_total, resv_cap, base;
  logic [WORD_BITS-1:0] avail, wr_data;
  logic [IDX_W-1:0]     hit_idx, bit_pos;
  logic                 wr_en, hit, scan_last, range_err, early, bit_new;
  logic [CNT_W:0]       word_end;

  // Effective total and reserved count, both capped
  assign eff_total = (total_q > MAX_CNT) ? MAX_CNT : total_q;
  assign resv_cap  = (resv_q < eff_total) ? resv_q : eff_total;

  // First block number held by the current word
  assign base     = {1'b0, addr_q, {IDX_W{1'b0}}};
  assign word_end = {1'b0, base} + (CNT_W+1)'(WORD_BITS);

  // Free, in-range bits of the scanned word and the lowest of them
  assign avail     = ~rd_data_q & low_mask(base, eff_total);
  assign hit       = |avail;
  assign scan_last = (word_end >= {1'b0, eff_total});

  always_comb begin
    hit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) hit_idx = IDX_W'(b);
    end
  end

  // Items that finish without touching the bitmap
  assign range_err = ({1'b0, blk_q} >= eff_total);
  always_comb begin
    early = 1'b0;
    if (kind_q == bba_pkg::KIND_ALLOC) begin
      early = (cnt_q == '0) || (eff_total == '0);
    end else if (kind_q inside {bba_pkg::KIND_FREE, bba_pkg::KIND_READ,
                                bba_pkg::KIND_WRITE}) begin
      early = range_err;
    end else if (kind_q != bba_pkg::KIND_FORMAT) begin
      early = 1'b1;
    end
  end

  assign st_o.kind       = kind_q;
  assign st_o.early      = early;
  assign st_o.hit        = hit;
  assign st_o.scan_last  = scan_last;
  assign st_o.sweep_last = (addr_q == LAST_ADDR);
  assign st_o.out_free   = !out_valid_q || !out_stall_i;

  // Next word address
  always_comb begin
    case (cmd_i.addr_sel)
      bba_pkg::ADDR_ZERO: addr_d = '0;
      bba_pkg::ADDR_BLK:  addr_d = blk_q[BLK_W-1:IDX_W];
      bba_pkg::ADDR_NEXT: addr_d = addr_q + AW'(1);
      default:            addr_d = addr_q;
    endcase
  end

  // Bitmap write data: claim, single-bit update or sweep fill
  assign bit_pos = blk_q[IDX_W-1:0];
  assign bit_new = (kind_q == bba_pkg::KIND_WRITE) ? bv_q : 1'b0;
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data_q;
    if (cmd_i.scan_hit) begin
      wr_en            = 1'b1;
      wr_data[hit_idx] = 1'b1;
    end else if (cmd_i.rmw) begin
      wr_en            = (kind_q != bba_pkg::KIND_READ);
      wr_data[bit_pos] = bit_new;
    end else if (cmd_i.sweep) begin
      wr_en   = 1'b1;
      wr_data = cmd_i.sweep_zero ? '0 : low_mask(base, resv_cap);
    end
  end

  // Result and free counter update
  always_comb begin
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    res_bit_d    = res_bit_q;
    cnt_d        = cnt_q;
    if (cmd_i.res_early) begin
      res_bit_d = 1'b0;
      if (kind_q == bba_pkg::KIND_ALLOC) begin
        res_status_d = bba_pkg::ST_NOFREE;
        res_block_d  = '0;
      end else if (kind_q inside {bba_pkg::KIND_FREE, bba_pkg::KIND_READ,
                                  bba_pkg::KIND_WRITE}) begin
        res_status_d = bba_pkg::ST_RANGE;
        res_block_d  = blk_q;
      end else begin
        res_status_d = bba_pkg::ST_OK;
        res_block_d  = '0;
      end
    end else if (cmd_i.scan_hit) begin
      res_status_d = bba_pkg::ST_OK;
      res_block_d  = {addr_q, hit_idx};
      res_bit_d    = 1'b1;
      cnt_d        = cnt_q - CNT_W'(1);
    end else if (cmd_i.rmw) begin
      res_status_d = bba_pkg::ST_OK;
      res_block_d  = blk_q;
      res_bit_d    = (kind_q == bba_pkg::KIND_READ) ? rd_data_q[bit_pos] : bit_new;
      if (kind_q == bba_pkg::KIND_FREE && cnt_q < eff_total) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else if (cmd_i.fmt_done) begin
      res_status_d = bba_pkg::ST_OK;
      res_block_d  = '0;
      res_bit_d    = 1'b0;
      cnt_d        = eff_total - resv_cap;
    end
  end

  // Bitmap memory, single port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[addr_d];
    end
  end

  // Capture the item and hold the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_kind_i;
      blk_q  <= in_block_number_i;
      bv_q   <= in_bit_value_i;
    end
    res_status_q <= res_status_d;
    res_block_q  <= res_block_d;
    res_bit_q    <= res_bit_d;
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_block_q  <= res_block_q;
      out_bit_q    <= res_bit_q;
      out_cnt_q    <= cnt_q;
    end
  end

  // Control state: config, counter, address, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_CNT;
      resv_q      <= '0;
      cnt_q       <= TOTAL_CNT;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bba_pkg::CFG_TOTAL: total_q <= cfg_data_i;
          bba_pkg::CFG_RESV:  resv_q  <= cfg_data_i;
          default:            total_q <= total_q;
        endcase
      end
      cnt_q  <= cnt_d;
      addr_q <= addr_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_result_block_o = out_block_q;
  assign out_result_bit_o   = out_bit_q;
  assign out_free_count_o   = out_cnt_q;

endmodule

`default_nettype wire

/* src/bba_ctrl.sv */
// Controller of the bitmap block allocator: sequences clearing, scan,
// single-bit and format passes and the hand-off to the output register.
// Depends on bba_pkg.
`default_nettype none

module bba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bba_pkg::st_t  st_i,
  output bba_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_RMW    = 3'd4;
  localparam logic [2:0] S_FMT    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.addr_sel = bba_pkg::ADDR_HOLD;
    case (state_q)
      S_INIT: begin
        // clear the whole bitmap after reset
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_zero = 1'b1;
        if (st_i.sweep_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.addr_sel = bba_pkg::ADDR_NEXT;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st_i.early) begin
          cmd_o.res_early = 1'b1;
          state_d         = S_FINISH;
        end else begin
          case (st_i.kind)
            bba_pkg::KIND_ALLOC: begin
              cmd_o.addr_sel = bba_pkg::ADDR_ZERO;
              cmd_o.rd_en    = 1'b1;
              state_d        = S_SCAN;
            end
            bba_pkg::KIND_FREE, bba_pkg::KIND_READ, bba_pkg::KIND_WRITE: begin
              cmd_o.addr_sel = bba_pkg::ADDR_BLK;
              cmd_o.rd_en    = 1'b1;
              state_d        = S_RMW;
            end
            default: begin
              // format
              cmd_o.addr_sel = bba_pkg::ADDR_ZERO;
              state_d        = S_FMT;
            end
          endcase
        end
      end
      S_SCAN: begin
        // one bitmap word per cycle until a free bit or the end of range
        if (st_i.hit) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = S_FINISH;
        end else if (st_i.scan_last) begin
          cmd_o.res_early = 1'b1;
          state_d         = S_FINISH;
        end else begin
          cmd_o.addr_sel = bba_pkg::ADDR_NEXT;
          cmd_o.rd_en    = 1'b1;
        end
      end
      S_RMW: begin
        cmd_o.rmw = 1'b1;
        state_d   = S_FINISH;
      end
      S_FMT: begin
        cmd_o.sweep = 1'b1;
        if (st_i.sweep_last) begin
          cmd_o.fmt_done = 1'b1;
          state_d        = S_FINISH;
        end else begin
          cmd_o.addr_sel = bba_pkg::ADDR_NEXT;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* src/bitmap_block_allocator_unit.sv */
// Top level of the first-fit bitmap block allocator: controller plus
// datapath. Depends on bba_pkg, bba_ctrl and bba_dp.
//
// The unit keeps one used/free bit per block in a single-port bitmap memory
// of MAX_BLOCKS/WORD_BITS words and handles one item at a time; the bitmap
// port moves one word per cycle. After reset a clearing pass writes all
// MAX_BLOCKS/WORD_BITS words (512 by default) while in_stall_o stays high;
// configuration writes are taken during it. Free, read bit and write bit
// pass from acceptance through decode, a read-modify-write of the block's
// bitmap word and the hand-off to the output register. Allocate scans the
// bitmap words from the first up to the first one with a free block or the
// end of range; an allocate that fails at once on a zero counter, an
// out-of-range block number and an unused kind finish without touching the
// bitmap. Format rewrites the whole bitmap. A finished result sits in the output
// register; a new item is accepted while it waits, and that item's result
// is held back until the register frees. MAX_BLOCKS and WORD_BITS must be
// powers of two; the unit itself does not enforce this.
`default_nettype none

module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [$clog2(MAX_BLOCKS):0]   cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    in_kind_i,
  input  logic [$clog2(MAX_BLOCKS)-1:0] in_block_number_i,
  input  logic                          in_bit_value_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    out_status_o,
  output logic [$clog2(MAX_BLOCKS)-1:0] out_result_block_o,
  output logic                          out_result_bit_o,
  output logic [$clog2(MAX_BLOCKS):0]   out_free_count_o
);

  bba_pkg::cmd_t cmd;
  bba_pkg::st_t  st;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_kind_i          (in_kind_i),
    .in_block_number_i  (in_block_number_i),
    .in_bit_value_i     (in_bit_value_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_status_o       (out_status_o),
    .out_result_block_o (out_result_block_o),
    .out_result_bit_o   (out_result_bit_o),
    .out_free_count_o   (out_free_count_o),
    .cmd_i              (cmd),
    .st_o               (st)
  );

  // A result enters the output register only when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> st.out_free)
    else $error("result loaded over an untaken result");

  // One item at a time: stall right after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item accepted while one is in progress");

  // At most one source updates the result in a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.res_early, cmd.scan_hit, cmd.rmw, cmd.fmt_done}))
    else $error("conflicting result updates");

  // A range error never reports a set bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == bba_pkg::ST_RANGE) |-> !out_result_bit_o)
    else $error("range error with result bit set");

endmodule

`default_nettype wire
